>>> hw/rtl/hrlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, constants and token classifiers for the HTTP request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int RAW_BYTES_DEF  = 1024;
  localparam int PATH_BYTES_DEF = 256;
  localparam int PREFIX_LEN     = 9;

  typedef enum logic [2:0] {
    PH_START, PH_LINE, PH_METHOD, PH_GAP_PATH, PH_PATH, PH_GAP_VER, PH_VERSION, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE, ESC_PCT, ESC_HEX1, ESC_DROP
  } esc_t;

  localparam logic [1:0] VD_PROCEED  = 2'd0;
  localparam logic [1:0] VD_BAD      = 2'd1;
  localparam logic [1:0] VD_NOTALLOW = 2'd2;
  localparam logic [1:0] VD_INTERNAL = 2'd3;

  localparam logic [2:0] METHOD_OTHER  = 3'd6;
  localparam logic [2:0] VERSION_OTHER = 3'd4;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] c1, input logic [7:0] c2,
                                          input logic has2);
    logic [4:0] d1;
    logic [4:0] d2;
    d1 = hex_digit(c1);
    d2 = has2 ? hex_digit(c2) : 5'd0;
    if (d1[4]) return d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
    if (!d2[4]) return 8'd0;
    if (c1 == 8'h20 || (c1 >= 8'h09 && c1 <= 8'h0d) || c1 == 8'h2b) return {4'd0, d2[3:0]};
    if (c1 == 8'h2d) return 8'd0 - {4'd0, d2[3:0]};
    return 8'd0;
  endfunction

  function automatic logic [2:0] method_of(input logic [47:0] ch, input logic [2:0] len);
    if (len == 3'd4 && ch[31:0] == 32'h44414548) return 3'd0;
    if (len == 3'd3 && ch[23:0] == 24'h544547) return 3'd1;
    if (len == 3'd4 && ch[31:0] == 32'h54534f50) return 3'd2;
    if (len == 3'd5 && ch[39:0] == 40'h4843544150) return 3'd3;
    if (len == 3'd3 && ch[23:0] == 24'h545550) return 3'd4;
    if (len == 3'd6 && ch == 48'h4554454c4544) return 3'd5;
    return METHOD_OTHER;
  endfunction

  function automatic logic [2:0] version_of(input logic [63:0] ch, input logic [3:0] len);
    if (len != 4'd8) return VERSION_OTHER;
    if (ch == 64'h302e312f50545448) return 3'd0;
    if (ch == 64'h312e312f50545448) return 3'd1;
    if (ch == 64'h302e322f50545448) return 3'd2;
    if (ch == 64'h302e332f50545448) return 3'd3;
    return VERSION_OTHER;
  endfunction

  function automatic logic [3:0] mime_of(input logic dot, input logic [31:0] ch,
                                         input logic [2:0] len);
    if (!dot) return 4'd0;
    if (len == 3'd4 && ch == 32'h6c6d7468) return 4'd1;
    if (len == 3'd3 && ch[23:0] == 24'h737363) return 4'd2;
    if (len == 3'd2 && ch[15:0] == 16'h736a) return 4'd3;
    if (len == 3'd3 && ch[23:0] == 24'h767363) return 4'd4;
    if (len == 3'd4 && ch == 32'h6765706a) return 4'd5;
    if (len == 3'd3 && ch[23:0] == 24'h67706a) return 4'd5;
    if (len == 3'd3 && ch[23:0] == 24'h676e70) return 4'd6;
    if (len == 3'd3 && ch[23:0] == 24'h666967) return 4'd7;
    if (len == 3'd4 && ch == 32'h6e6f736a) return 4'd8;
    if (len == 3'd3 && ch[23:0] == 24'h667773) return 4'd9;
    return 4'd0;
  endfunction

endpackage

>>> hw/rtl/hrlp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_in_if / hrlp_out_if
// Valid/ready channels for request bytes and parser results.
// ----------------------------------------------------------------------------
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] path_byte;
  logic [1:0] verdict;
  logic [2:0] method_code;
  logic [2:0] version_code;
  logic [3:0] mime_code;
  logic       last_item;
  modport source (output valid, result_kind, path_byte, verdict, method_code, version_code,
                  mime_code, last_item, input ready);
  modport sink (input valid, result_kind, path_byte, verdict, method_code, version_code,
                mime_code, last_item, output ready);
endinterface

>>> hw/rtl/http_request_line_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Parses the request line byte by byte and emits path bytes and a verdict.
// The result of an accepted byte is written into the output register as the byte is taken.
// Throughput: one byte per cycle; the output register is refilled in the cycle
// it is taken, so the input stalls only while a result waits unread.
// Reset: synchronous active-low rst_n clears all parser state and the output valid flag.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit #(
  parameter int RAW_BYTES  = hrlp_pkg::RAW_BYTES_DEF,
  parameter int PATH_BYTES = hrlp_pkg::PATH_BYTES_DEF
) (
  input logic clk,
  input logic rst_n,
  hrlp_in_if.sink in_ch,
  hrlp_out_if.source out_ch
);
  import hrlp_pkg::*;

  localparam int PATH_LIMIT = (PATH_BYTES > PREFIX_LEN) ? PATH_BYTES - PREFIX_LEN : 0;
  localparam int BCW = $clog2(RAW_BYTES + 1);
  localparam int PLW = $clog2(PATH_LIMIT + 2);

  phase_t      phase_r, phase_nxt;
  logic [47:0] mch_r, mch_nxt;
  logic [2:0]  mlen_r, mlen_nxt;
  logic [63:0] vch_r, vch_nxt;
  logic [3:0]  vlen_r, vlen_nxt;
  esc_t        esc_r, esc_nxt;
  logic [7:0]  hex_r, hex_nxt;
  logic [15:0] recent_r, recent_nxt;
  logic        dd_r, dd_nxt;
  logic [31:0] ech_r, ech_nxt;
  logic [2:0]  elen_r, elen_nxt;
  logic        edot_r, edot_nxt;
  logic [1:0]  tm_r, tm_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic [PLW-1:0] pl_r, pl_nxt;
  logic        blind_r, blind_nxt;

  logic        ov_r, okind_r, olast_r;
  logic [7:0]  obyte_r;
  logic [1:0]  overd_r;
  logic [2:0]  ometh_r, over_r;
  logic [3:0]  omime_r;

  logic take;
  logic have, term, fin, res_v;
  logic [7:0] outb;
  logic [1:0] vd;
  logic [7:0] c;

  assign in_ch.ready = !ov_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign c = in_ch.data_byte;

  always_comb begin
    logic eol, sp, pend;
    logic [7:0] pb;
    logic       pbv;
    logic [2:0] mc;
    logic [2:0] vc;
    phase_nxt = phase_r; mch_nxt = mch_r; mlen_nxt = mlen_r; vch_nxt = vch_r;
    vlen_nxt = vlen_r; esc_nxt = esc_r; hex_nxt = hex_r; recent_nxt = recent_r;
    dd_nxt = dd_r; ech_nxt = ech_r; elen_nxt = elen_r; edot_nxt = edot_r;
    tm_nxt = tm_r; bc_nxt = bc_r; pl_nxt = pl_r; blind_nxt = blind_r;
    have = 1'b0; term = 1'b0; fin = 1'b0; outb = 8'd0; vd = VD_BAD;
    eol = (c == 8'h0d) || (c == 8'h0a);
    sp = (c == 8'h20);
    pend = 1'b0; pb = 8'd0; pbv = 1'b0;
    mc = METHOD_OTHER; vc = VERSION_OTHER;
    if (in_ch.action) begin
      fin = 1'b1;
    end else begin
      bc_nxt = bc_r + 1'b1;
      if (!blind_r) begin
        if (c == 8'h0d) tm_nxt = (tm_r == 2'd2) ? 2'd3 : 2'd1;
        else if (c == 8'h0a && tm_r == 2'd1) tm_nxt = 2'd2;
        else if (c == 8'h0a && tm_r == 2'd3) begin
          tm_nxt = 2'd0;
          if (bc_r == BCW'(3)) blind_nxt = 1'b1; else term = 1'b1;
        end else tm_nxt = 2'd0;
        if (c == 8'd0) blind_nxt = 1'b1;
      end
      if (!blind_nxt) begin
        unique case (phase_r)
          PH_START, PH_LINE: begin
            if (eol) begin
              if (phase_r == PH_LINE) phase_nxt = PH_DONE;
            end else if (sp) phase_nxt = PH_LINE;
            else begin
              if (mlen_r < 3'd6) begin
                mch_nxt[8*mlen_r[2:0] +: 8] = c;
                mlen_nxt = mlen_r + 3'd1;
              end else mlen_nxt = 3'd7;
              phase_nxt = PH_METHOD;
            end
          end
          PH_METHOD: begin
            if (sp) phase_nxt = PH_GAP_PATH;
            else if (eol) phase_nxt = PH_DONE;
            else if (mlen_r < 3'd6) begin
              mch_nxt[8*mlen_r[2:0] +: 8] = c;
              mlen_nxt = mlen_r + 3'd1;
            end else mlen_nxt = 3'd7;
          end
          PH_GAP_PATH, PH_PATH: begin
            if ((phase_r == PH_GAP_PATH && sp) || (phase_r == PH_GAP_PATH && eol)) begin
              if (eol) phase_nxt = PH_DONE;
            end else if (sp || eol) begin
              pend = 1'b1;
              phase_nxt = sp ? PH_GAP_VER : PH_DONE;
            end else begin
              phase_nxt = PH_PATH;
              if (esc_r != ESC_DROP) begin
                if (c == 8'h3f) pend = 1'b1;
                else if (esc_r == ESC_PCT) begin
                  hex_nxt = c; esc_nxt = ESC_HEX1;
                end else if (esc_r == ESC_HEX1) begin
                  esc_nxt = ESC_NONE; pb = hex_pair(hex_r, c, 1'b1); pbv = 1'b1;
                end else if (c == 8'h25) esc_nxt = ESC_PCT;
                else begin
                  pb = c; pbv = 1'b1;
                end
              end
            end
            if (pend) begin
              if (esc_r == ESC_HEX1) begin
                pb = hex_pair(hex_r, 8'd0, 1'b0); pbv = 1'b1;
              end
              esc_nxt = ESC_DROP;
            end
            if (pbv) begin
              if (pb == 8'd0) esc_nxt = ESC_DROP;
              else if (pl_r >= PLW'(PATH_LIMIT)) begin
                pl_nxt = PLW'(PATH_LIMIT + 1); esc_nxt = ESC_DROP;
              end else begin
                pl_nxt = pl_r + 1'b1;
                if (pb == 8'h2e && recent_r == 16'h2f2e) dd_nxt = 1'b1;
                recent_nxt = {recent_r[7:0], pb};
                if (pb == 8'h2e) begin
                  edot_nxt = 1'b1; ech_nxt = 32'd0; elen_nxt = 3'd0;
                end else if (edot_r && elen_r < 3'd5) begin
                  if (elen_r < 3'd4) ech_nxt[8*elen_r[1:0] +: 8] = pb;
                  elen_nxt = elen_r + 3'd1;
                end
                have = 1'b1; outb = pb;
              end
            end
          end
          PH_GAP_VER, PH_VERSION: begin
            if (sp) begin
              if (phase_r == PH_VERSION) phase_nxt = PH_DONE;
            end else if (eol) phase_nxt = PH_DONE;
            else begin
              phase_nxt = PH_VERSION;
              if (vlen_r < 4'd8) begin
                vch_nxt[8*vlen_r[2:0] +: 8] = c;
                vlen_nxt = vlen_r + 4'd1;
              end else vlen_nxt = 4'd9;
            end
          end
          default: ;
        endcase
      end
      if (term) begin
        fin = 1'b1;
        mc = method_of(mch_r, mlen_r);
        vc = version_of(vch_r, vlen_r);
        if (vlen_r == 4'd0 || pl_r > PLW'(PATH_LIMIT)) vd = VD_BAD;
        else if (mc > 3'd2) vd = (mc == METHOD_OTHER) ? VD_INTERNAL : VD_NOTALLOW;
        else if (vc == VERSION_OTHER) vd = VD_INTERNAL;
        else vd = dd_r ? VD_BAD : VD_PROCEED;
      end else if (bc_nxt >= BCW'(RAW_BYTES)) fin = 1'b1;
    end
  end

  assign res_v = fin || have;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; mch_r <= '0; mlen_r <= '0; vch_r <= '0; vlen_r <= '0;
      esc_r <= ESC_NONE; hex_r <= '0; recent_r <= '0; dd_r <= 1'b0; ech_r <= '0;
      elen_r <= '0; edot_r <= 1'b0; tm_r <= '0; bc_r <= '0; pl_r <= '0; blind_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        if (fin) begin
          phase_r <= PH_START; mch_r <= '0; mlen_r <= '0; vch_r <= '0; vlen_r <= '0;
          esc_r <= ESC_NONE; hex_r <= '0; recent_r <= '0; dd_r <= 1'b0; ech_r <= '0;
          elen_r <= '0; edot_r <= 1'b0; tm_r <= '0; bc_r <= '0; pl_r <= '0;
          blind_r <= 1'b0;
        end else begin
          phase_r <= phase_nxt; mch_r <= mch_nxt; mlen_r <= mlen_nxt; vch_r <= vch_nxt;
          vlen_r <= vlen_nxt; esc_r <= esc_nxt; hex_r <= hex_nxt; recent_r <= recent_nxt;
          dd_r <= dd_nxt; ech_r <= ech_nxt; elen_r <= elen_nxt; edot_r <= edot_nxt;
          tm_r <= tm_nxt; bc_r <= bc_nxt; pl_r <= pl_nxt; blind_r <= blind_nxt;
        end
      end
      if (take) ov_r <= res_v;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_v) begin
      okind_r <= fin;
      obyte_r <= fin ? 8'd0 : outb;
      overd_r <= fin ? vd : VD_PROCEED;
      ometh_r <= fin ? method_of(mch_nxt, mlen_nxt) : 3'd0;
      over_r  <= fin ? version_of(vch_nxt, vlen_nxt) : 3'd0;
      omime_r <= (fin && elen_nxt >= 3'd1 && elen_nxt <= 3'd4) ?
                 mime_of(edot_nxt, ech_nxt, elen_nxt) : 4'd0;
      olast_r <= fin;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.result_kind  = okind_r;
  assign out_ch.path_byte    = obyte_r;
  assign out_ch.verdict      = overd_r;
  assign out_ch.method_code  = ometh_r;
  assign out_ch.version_code = over_r;
  assign out_ch.mime_code    = omime_r;
  assign out_ch.last_item    = olast_r;
endmodule

>>> hw/rtl/hrlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks on the parser result channel.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_path_byte,
  input logic       out_last_item
);
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_item == out_result_kind)) else $error("last_item mismatch");
  a_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_kind) |-> (out_path_byte != 8'd0)) else $error("zero path byte");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stall without pending result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind http_request_line_parser_unit hrlp_checker u_hrlp_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_kind(out_ch.result_kind), .out_path_byte(out_ch.path_byte),
  .out_last_item(out_ch.last_item)
);
